// File: rtl/cfcd_pkg.sv
package cfcd_pkg;

    // Default sizing of the frame buffer and the coil array
    localparam int FRAME_MAX_BYTES_DEF = 8;
    localparam int TILE_COUNT_DEF      = 16;
    localparam int COILS_PER_TILE_DEF  = 9;

    // Byte codes of the framed stream and of the command set
    localparam logic [7:0] DELIM        = 8'h00;
    localparam logic [7:0] GROUP_FULL   = 8'hFF;
    localparam logic [7:0] CMD_SETPOINT = 8'h80;
    localparam logic [7:0] CMD_IDENTIFY = 8'h82;

    // Decoded frame layout
    localparam int DEC_KEEP          = 7;   // decoded bytes that feed any output
    localparam int MIN_DEC_LEN       = 3;   // lead zero, register byte, one data byte
    localparam int PAYLOAD_BYTES     = 5;
    localparam int LEN_SAT           = 7;
    localparam int SETPOINT_DATA_LEN = 4;
    localparam int IDENTIFY_DATA_LEN = 1;

    typedef enum logic [1:0] {
        KIND_REG_WRITE = 2'd0,
        KIND_SETPOINT  = 2'd1,
        KIND_IDENTIFY  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind        kind;
        logic [6:0]   reg_addr;
        logic [2:0]   payload_len;
        logic [39:0]  payload;
        logic [7:0]   tile_id;
        logic [3:0]   coil_num;
        logic [15:0]  setpoint;
    } t_cmd;

endpackage

// File: rtl/cobs_framed_command_decoder_core.sv
// COBS framed command decoder.
// Input channel: one received byte per request on i_rx_byte, qualified by
// i_rx_valid and held off by o_rx_stall. A zero byte is the frame delimiter;
// the first delimiter after reset brings the decoder into sync.
// Output channel: one command per accepted frame on o_kind .. o_setpoint,
// qualified by o_cmd_valid and held off by i_cmd_stall. Fields a command
// kind does not use read as zero. Bad, short or unknown frames give nothing.
// The command is registered as its delimiter is accepted.
// Throughput: one byte per cycle while o_rx_stall is low; the frame is
// decoded on the fly, so the delimiter only classifies the decoded bytes.
// When the receiver stalls, the output register holds its command and a
// one-entry skid stage takes the next one; o_rx_stall rises only once that
// skid stage is occupied, and bytes without a command keep flowing until
// then.
// Reset (synchronous, active low) clears sync, the frame count and both
// output stages; no clearing pass is needed.
module cobs_framed_command_decoder_core
    import cfcd_pkg::*;
#(
    parameter int FRAME_MAX_BYTES = FRAME_MAX_BYTES_DEF,
    parameter int TILE_COUNT      = TILE_COUNT_DEF,
    parameter int COILS_PER_TILE  = COILS_PER_TILE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_cmd_valid,
    input  logic        i_cmd_stall,
    output logic [1:0]  o_kind,
    output logic [6:0]  o_reg_addr,
    output logic [2:0]  o_payload_len,
    output logic [39:0] o_payload,
    output logic [7:0]  o_tile_id,
    output logic [3:0]  o_coil_num,
    output logic [15:0] o_setpoint
);

    logic r_out_valid;
    t_cmd r_out;
    logic r_skid_valid;
    t_cmd r_skid;

    logic accept;
    logic res_valid;
    t_cmd res;
    logic out_free;

    assign o_rx_stall = r_skid_valid;
    assign accept     = i_rx_valid && !r_skid_valid;
    assign out_free   = !r_out_valid || !i_cmd_stall;

    cfcd_frame #(
        .FRAME_MAX_BYTES(FRAME_MAX_BYTES),
        .TILE_COUNT     (TILE_COUNT),
        .COILS_PER_TILE (COILS_PER_TILE)
    ) u_frame (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_rx_byte  (i_rx_byte),
        .o_cmd_valid(res_valid),
        .o_cmd      (res)
    );

    // Advance the output register; park a command in the skid stage on stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : res;
        end
        if (!out_free && res_valid) begin
            r_skid <= res;
        end
    end

    assign o_cmd_valid   = r_out_valid;
    assign o_kind        = r_out.kind;
    assign o_reg_addr    = r_out.reg_addr;
    assign o_payload_len = r_out.payload_len;
    assign o_payload     = r_out.payload;
    assign o_tile_id     = r_out.tile_id;
    assign o_coil_num    = r_out.coil_num;
    assign o_setpoint    = r_out.setpoint;

endmodule

// File: rtl/cfcd_frame.sv
module cfcd_frame
    import cfcd_pkg::*;
#(
    parameter int FRAME_MAX_BYTES = FRAME_MAX_BYTES_DEF,
    parameter int TILE_COUNT      = TILE_COUNT_DEF,
    parameter int COILS_PER_TILE  = COILS_PER_TILE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd
);

    localparam int CW = $clog2(FRAME_MAX_BYTES + 1);

    // Frame tracking state; decoded bytes are built as the raw bytes arrive
    logic          r_synced,  n_synced;
    logic [CW-1:0] r_count,   n_count;
    logic [7:0]    r_rem,     n_rem;
    logic          r_prev_ff, n_prev_ff;
    logic [CW-1:0] r_wr,      n_wr;
    logic [7:0]    r_dec [DEC_KEEP];

    logic          dec_we;
    logic [7:0]    dec_wdata;
    logic          is_delim;

    assign is_delim = (i_rx_byte == DELIM);

    // Advance the incremental decoder by one stored byte
    always_comb begin
        n_synced  = r_synced;
        n_count   = r_count;
        n_rem     = r_rem;
        n_prev_ff = r_prev_ff;
        n_wr      = r_wr;
        dec_we    = 1'b0;
        dec_wdata = i_rx_byte;
        if (i_accept) begin
            if (is_delim) begin
                n_synced = 1'b1;
                n_count  = '0;
                n_rem    = '0;
                n_wr     = '0;
            end else if (r_count < CW'(FRAME_MAX_BYTES) && r_synced) begin
                n_count = r_count + 1'b1;
                if (r_count == '0) begin
                    // first group code of the frame
                    n_rem     = i_rx_byte - 8'd1;
                    n_prev_ff = (i_rx_byte == GROUP_FULL);
                    n_wr      = '0;
                end else if (r_rem == '0) begin
                    // next group code: close the previous group with a zero unless it was full
                    n_rem     = i_rx_byte - 8'd1;
                    n_prev_ff = (i_rx_byte == GROUP_FULL);
                    if (!r_prev_ff) begin
                        dec_we    = 1'b1;
                        dec_wdata = DELIM;
                        n_wr      = r_wr + 1'b1;
                    end
                end else begin
                    dec_we = 1'b1;
                    n_rem  = r_rem - 8'd1;
                    n_wr   = r_wr + 1'b1;
                end
            end else begin
                // before sync or on overflow: drop and restart the count
                n_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_synced  <= 1'b0;
            r_count   <= '0;
            r_rem     <= '0;
            r_prev_ff <= 1'b0;
            r_wr      <= '0;
        end else begin
            r_synced  <= n_synced;
            r_count   <= n_count;
            r_rem     <= n_rem;
            r_prev_ff <= n_prev_ff;
            r_wr      <= n_wr;
        end
    end

    // Keep only the decoded bytes that reach an output
    always_ff @(posedge i_clk) begin
        if (dec_we && r_wr < CW'(DEC_KEEP)) begin
            r_dec[r_wr[2:0]] <= dec_wdata;
        end
    end

    // Classify the decoded frame at its delimiter
    logic [CW-1:0] dsize;
    logic          frame_ok;
    logic          is_write;
    logic          is_sp;
    logic          is_id;

    assign dsize    = r_wr - CW'(2);
    assign frame_ok = (r_count > CW'(2)) && (r_rem == '0)
                   && (r_wr >= CW'(MIN_DEC_LEN)) && (r_dec[0] == DELIM);
    assign is_write = !r_dec[1][7];
    assign is_sp    = (r_dec[1] == CMD_SETPOINT) && (dsize == CW'(SETPOINT_DATA_LEN))
                   && ({1'b0, r_dec[2]} < 9'(TILE_COUNT))
                   && ({1'b0, r_dec[3]} < 9'(COILS_PER_TILE));
    assign is_id    = (r_dec[1] == CMD_IDENTIFY) && (dsize == CW'(IDENTIFY_DATA_LEN));

    assign o_cmd_valid = i_accept && is_delim && frame_ok && (is_write || is_sp || is_id);

    // Build the command fields, zero where the kind does not use them
    always_comb begin
        o_cmd = '0;
        if (is_write) begin
            o_cmd.kind        = KIND_REG_WRITE;
            o_cmd.reg_addr    = r_dec[1][6:0];
            o_cmd.payload_len = (dsize < CW'(LEN_SAT)) ? dsize[2:0] : 3'(LEN_SAT);
            for (int k = 0; k < PAYLOAD_BYTES; k++) begin
                if (CW'(k) < dsize) begin
                    o_cmd.payload[8*k +: 8] = r_dec[2+k];
                end
            end
        end else if (is_sp) begin
            o_cmd.kind     = KIND_SETPOINT;
            o_cmd.tile_id  = r_dec[2];
            o_cmd.coil_num = r_dec[3][3:0];
            o_cmd.setpoint = {r_dec[5], r_dec[4]};
        end else begin
            o_cmd.kind    = KIND_IDENTIFY;
            o_cmd.tile_id = r_dec[2];
        end
    end

endmodule
